// File: rtl/fdc_command_result_seek_engine_core_macros.svh
// assertion macros shared by the floppy controller rtl files
// needs a clock i_clk and an active low reset i_rst_n in the using module
`ifndef FDC_COMMAND_RESULT_SEEK_ENGINE_CORE_MACROS_SVH
`define FDC_COMMAND_RESULT_SEEK_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define FDC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdc assertion failed");

// next-cycle implication
`define FDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdc assertion failed");

`endif

// File: rtl/fdc_pkg.sv
// shared types, command codes and decode helpers of the floppy controller
// no dependencies
package fdc_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_STATUS = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_FINISH = 3'd4,
        KIND_NOP    = 3'd5
    } t_kind;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_READY = 3'd1;
    localparam logic [2:0] ERR_PROTECT   = 3'd2;
    localparam logic [2:0] ERR_MISSING   = 3'd3;
    localparam logic [2:0] ERR_OTHER     = 3'd4;
    localparam logic [2:0] ERR_INVALID   = 3'd5;

    localparam logic [4:0] CMD_READ_TRACK = 5'h02;
    localparam logic [4:0] CMD_SPECIFY    = 5'h03;
    localparam logic [4:0] CMD_SENSE_DRV  = 5'h04;
    localparam logic [4:0] CMD_WRITE      = 5'h05;
    localparam logic [4:0] CMD_READ       = 5'h06;
    localparam logic [4:0] CMD_RECAL      = 5'h07;
    localparam logic [4:0] CMD_SENSE_INT  = 5'h08;
    localparam logic [4:0] CMD_WRITE_DEL  = 5'h09;
    localparam logic [4:0] CMD_READ_ID    = 5'h0A;
    localparam logic [4:0] CMD_READ_DEL   = 5'h0C;
    localparam logic [4:0] CMD_FORMAT     = 5'h0D;
    localparam logic [4:0] CMD_SEEK       = 5'h0F;
    localparam logic [4:0] CMD_SCAN_EQ    = 5'h11;
    localparam logic [4:0] CMD_SCAN_LE    = 5'h19;
    localparam logic [4:0] CMD_SCAN_HE    = 5'h1D;

    // one classified input item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_in;
        logic [3:0] ready_lines;
        logic [3:0] track0_lines;
        logic [3:0] protect_lines;
        logic [7:0] status1;
        logic [7:0] status2;
        logic [2:0] error;
        logic [7:0] cylinder;
        logic [7:0] head;
        logic [7:0] sector;
        logic [7:0] size;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] step_out;
        logic [3:0] step_in;
        logic       exec_start;
        logic [7:0] exec_command;
    } t_result;

    typedef struct packed {
        logic       bad;
        logic [3:0] count;
    } t_cmd_info;

    // read, write, scan and format commands
    function automatic logic f_is_rw(input logic [4:0] c);
        logic r;
        case (c) inside
            CMD_READ_TRACK, CMD_WRITE, CMD_READ, CMD_WRITE_DEL, CMD_READ_ID,
            CMD_READ_DEL, CMD_FORMAT, CMD_SCAN_EQ, CMD_SCAN_LE, CMD_SCAN_HE: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // parameter count and validity of a command byte
    function automatic t_cmd_info f_params(input logic [7:0] n);
        t_cmd_info r;
        r.bad   = 1'b0;
        r.count = 4'd0;
        unique case (n[4:0]) inside
            CMD_READ_TRACK: begin r.bad = n[7]; r.count = 4'd8; end
            CMD_SPECIFY, CMD_SEEK: begin r.bad = |n[7:5]; r.count = 4'd2; end
            CMD_SENSE_DRV, CMD_RECAL: begin r.bad = |n[7:5]; r.count = 4'd1; end
            CMD_WRITE, CMD_WRITE_DEL: begin r.bad = n[5]; r.count = 4'd8; end
            CMD_READ, CMD_READ_DEL, CMD_SCAN_EQ, CMD_SCAN_LE, CMD_SCAN_HE: begin
                r.count = 4'd8;
            end
            CMD_SENSE_INT: begin r.bad = |n[7:5]; r.count = 4'd0; end
            CMD_READ_ID: begin r.bad = n[7] | n[5]; r.count = 4'd1; end
            CMD_FORMAT: begin r.bad = n[7] | n[5]; r.count = 4'd5; end
            default: r.bad = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/fdc_fifo.sv
// small register queue used between the pipeline parts
// no dependencies beyond the assertion macro header
`include "fdc_command_result_seek_engine_core_macros.svh"
module fdc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_dout  = r_mem[r_rp];

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_din;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `FDC_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= CW'(DEPTH))
    `FDC_ASSERT_NEXT(a_cnt_grow, do_wr && !do_rd, r_cnt == $past(r_cnt) + 1'b1)
endmodule

// File: rtl/fdc_front.sv
// front part: accepts input items, classifies the kind and clamps the error code
// depends on fdc_pkg and fdc_fifo
module fdc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [2:0]     i_kind,
    input  logic [7:0]     i_data_in,
    input  logic [3:0]     i_ready_lines,
    input  logic [3:0]     i_track0_lines,
    input  logic [3:0]     i_protect_lines,
    input  logic [7:0]     i_finish_status1,
    input  logic [7:0]     i_finish_status2,
    input  logic [2:0]     i_finish_error,
    input  logic [7:0]     i_finish_cylinder,
    input  logic [7:0]     i_finish_head,
    input  logic [7:0]     i_finish_sector,
    input  logic [7:0]     i_finish_size,
    input  logic           i_take,
    output logic           o_valid,
    output fdc_pkg::t_item o_item
);
    fdc_pkg::t_item item;
    logic           empty;
    logic [$bits(fdc_pkg::t_item)-1:0] dout;

    // classify the item kind
    always_comb begin
        item = '0;
        case (i_kind)
            3'd0: item.kind = fdc_pkg::KIND_WRITE;
            3'd1: item.kind = fdc_pkg::KIND_READ;
            3'd2: item.kind = fdc_pkg::KIND_STATUS;
            3'd3: item.kind = fdc_pkg::KIND_TICK;
            3'd4: item.kind = fdc_pkg::KIND_FINISH;
            default: item.kind = fdc_pkg::KIND_NOP;
        endcase
        item.data_in       = i_data_in;
        item.ready_lines   = i_ready_lines;
        item.track0_lines  = i_track0_lines;
        item.protect_lines = i_protect_lines;
        item.status1       = i_finish_status1;
        item.status2       = i_finish_status2;
        item.error         = (i_finish_error > fdc_pkg::ERR_OTHER) ?
                             fdc_pkg::ERR_OTHER : i_finish_error;
        item.cylinder      = i_finish_cylinder;
        item.head          = i_finish_head;
        item.sector        = i_finish_sector;
        item.size          = i_finish_size;
    end

    // queue toward the back part
    fdc_fifo #(
        .WIDTH ($bits(fdc_pkg::t_item)),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_din   (item),
        .o_full  (o_full),
        .i_rd    (i_take),
        .o_dout  (dout),
        .o_empty (empty)
    );

    assign o_valid = !empty;
    assign o_item  = fdc_pkg::t_item'(dout);
endmodule

// File: rtl/fdc_back.sv
// back part: controller state, command execution, step engines, result queue
// depends on fdc_pkg, fdc_fifo and the assertion macro header
`include "fdc_command_result_seek_engine_core_macros.svh"
module fdc_back #(
    parameter int NUM_DRIVES      = 4,
    parameter int RECAL_MAX_STEPS = 77
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_take,
    input  fdc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_read_data,
    output logic [3:0]     o_step_out_pulses,
    output logic [3:0]     o_step_in_pulses,
    output logic           o_exec_start,
    output logic [7:0]     o_exec_command
);
    typedef struct packed {
        logic [1:0]      phase;
        logic            rd;
        logic            nrf;
        logic [7:0]      cmd;
        logic [3:0]      btot;
        logic [3:0]      bleft;
        logic [6:0][7:0] rb;
        logic [8:0][7:0] cf;
        logic [7:0]      st1;
        logic [7:0]      st2;
        logic [4:0]      sp;
        logic [7:0]      unload;
        logic [7:0]      load;
        logic [3:0][7:0] pc;
        logic [3:0][7:0] tc;
        logic [3:0][6:0] rl;
        logic [3:0][4:0] tmr;
        logic [3:0][7:0] irq;
        logic [3:0]      dr;
    } t_st;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_EXEC = 2'd2;
    localparam logic [1:0] PH_RES  = 2'd3;
    localparam logic [3:0] MASK    = 4'((1 << NUM_DRIVES) - 1);

    t_st              r_st, n_st;
    fdc_pkg::t_result res;
    logic             out_full;
    logic [$bits(fdc_pkg::t_result)-1:0] dout;
    fdc_pkg::t_result out_res;

    // seek or recalibrate completion
    function automatic t_st f_seek_done(input t_st s, input logic [1:0] d, input logic recal,
                                        input logic notrdy, input logic t0);
        t_st r;
        r = s;
        r.tc[d]  = s.pc[d];
        r.rl[d]  = '0;
        r.tmr[d] = '0;
        r.irq[d] = (s.irq[d] & 8'hC0) | 8'h20 |
                   ((recal && !(notrdy || t0)) ? 8'h10 : 8'h00) |
                   (notrdy ? 8'h08 : 8'h00) | {5'd0, s.cf[1][0], 2'd0};
        return r;
    endfunction

    // build the result bytes of the current command
    function automatic t_st f_begin(input t_st s, input logic [2:0] err,
                                    input logic [3:0] t0m, input logic [3:0] pm);
        t_st        r;
        logic [1:0] unit;
        logic       side;
        logic [4:0] code;
        logic [7:0] st0;
        logic       found;
        r     = s;
        unit  = s.cf[0][1:0];
        side  = s.cf[1][0];
        code  = s.cmd[4:0];
        st0   = 8'h80;
        found = 1'b0;
        r.btot = '0;
        if (s.phase != PH_IDLE) begin
            if (err == fdc_pkg::ERR_INVALID) begin
                r.rb[0] = 8'h80;
                r.btot  = 4'd1;
            end else if (fdc_pkg::f_is_rw(code)) begin
                st0 = {5'd0, side, unit};
                if (err != fdc_pkg::ERR_NONE) begin
                    st0 = st0 | 8'h40;
                    if (err == fdc_pkg::ERR_NOT_READY) begin
                        st0 = st0 | 8'h08;
                    end else if (err == fdc_pkg::ERR_PROTECT) begin
                        r.st1 = r.st1 | 8'h02;
                    end else if (err == fdc_pkg::ERR_MISSING) begin
                        r.st1 = r.st1 | 8'h05;
                    end
                end
                r.rb[0] = st0;
                r.rb[1] = r.st1;
                r.rb[2] = r.st2;
                r.rb[3] = s.cf[2];
                r.rb[4] = s.cf[3];
                r.rb[5] = s.cf[4];
                r.rb[6] = s.cf[5];
                r.btot  = 4'd7;
            end else if (code == fdc_pkg::CMD_SENSE_DRV) begin
                r.rb[0] = {1'b0, pm[unit], s.dr[unit], t0m[unit], 1'b0, side, unit};
                r.btot  = 4'd1;
            end else if (code == fdc_pkg::CMD_SENSE_INT) begin
                for (int i = 0; i < 4; i++) begin
                    if (!found && r.irq[i] != 8'h00) begin
                        found = 1'b1;
                        if (r.irq[i][5]) begin
                            st0 = {6'd0, 2'(i)} | (r.irq[i] & 8'h3C) |
                                  {1'b0, r.irq[i][3], 6'd0};
                            r.irq[i] = r.irq[i] & 8'hC0;
                        end else begin
                            r.irq[i] = 8'h00;
                            st0 = {6'd0, 2'(i)} | (r.dr[i] ? 8'h00 : 8'h08) | 8'hC0;
                        end
                    end
                end
                r.rb[0] = st0;
                if (st0 == 8'h80) begin
                    r.btot = 4'd1;
                end else begin
                    r.rb[1] = r.pc[st0[1:0]];
                    r.btot  = 4'd2;
                end
            end
        end
        r.bleft = r.btot;
        if (r.btot != 4'd0) begin
            r.phase = PH_RES;
            r.rd    = 1'b1;
        end else begin
            r.phase = PH_IDLE;
            r.rd    = 1'b0;
        end
        r.nrf = 1'b0;
        return r;
    endfunction

    // store one parameter byte
    function automatic t_st f_store(input t_st s, input logic [3:0] idx, input logic [7:0] n);
        t_st        r;
        logic [4:0] c;
        r = s;
        c = s.cmd[4:0];
        case (idx)
            4'd0: begin
                if (c == fdc_pkg::CMD_SPECIFY) begin
                    r.sp     = 5'd16 - {1'b0, n[7:4]};
                    r.unload = {n[3:0], 4'd0};
                    if (r.unload == 8'd0) r.unload = 8'hFF;
                end else begin
                    r.cf[0] = {6'd0, n[1:0]};
                    r.cf[1] = {7'd0, n[2]};
                end
            end
            4'd1: begin
                if (c == fdc_pkg::CMD_SPECIFY) begin
                    r.load = {n[7:1], 1'b0};
                    if (r.load == 8'd0) r.load = 8'hFF;
                end else if (c == fdc_pkg::CMD_FORMAT) begin
                    r.cf[5] = n;
                end else if (c == fdc_pkg::CMD_SEEK) begin
                    r.tc[s.cf[0][1:0]] = n;
                end else begin
                    r.cf[2] = n;
                end
            end
            4'd2: begin
                if (c == fdc_pkg::CMD_FORMAT) r.cf[6] = n;
                else r.cf[3] = n;
            end
            4'd3: begin
                if (c == fdc_pkg::CMD_READ_TRACK) r.cf[4] = 8'd1;
                else if (c == fdc_pkg::CMD_FORMAT) r.cf[7] = n;
                else r.cf[4] = n;
            end
            4'd4: begin
                if (c == fdc_pkg::CMD_FORMAT) r.cf[8] = n;
                else r.cf[5] = n;
            end
            4'd5: r.cf[6] = n;
            4'd6: r.cf[7] = n;
            4'd7: r.cf[8] = n;
            default: r = s;
        endcase
        return r;
    endfunction

    assign o_take = i_valid && !out_full;

    // one item through the controller
    always_comb begin
        t_st        s;
        logic [3:0] rdy, t0m, pm, idx;
        logic [1:0] unit;
        logic [4:0] code;
        logic       do_run, hold;
        fdc_pkg::t_cmd_info info;
        s      = r_st;
        rdy    = i_item.ready_lines & MASK;
        t0m    = i_item.track0_lines & MASK;
        pm     = i_item.protect_lines & MASK;
        unit   = r_st.cf[0][1:0];
        code   = '0;
        do_run = 1'b0;
        hold   = 1'b0;
        idx    = '0;
        info   = '0;
        res    = '0;
        res.read_data = 8'hFF;

        // ready line sampling
        for (int i = 0; i < 4; i++) begin
            if (i < NUM_DRIVES && rdy[i] != s.dr[i]) begin
                s.dr[i]  = rdy[i];
                s.irq[i] = s.irq[i] | 8'hC0;
                if (s.phase == PH_EXEC && 2'(i) == unit) begin
                    s = f_begin(s, fdc_pkg::ERR_NOT_READY, t0m, pm);
                end
            end
        end

        case (i_item.kind)
            fdc_pkg::KIND_WRITE: begin
                if (!(s.rd || s.nrf)) begin
                    if (s.phase == PH_IDLE) begin
                        s.phase = PH_CMD;
                        s.cmd   = i_item.data_in;
                        info    = fdc_pkg::f_params(i_item.data_in);
                        if (info.bad) begin
                            s = f_begin(s, fdc_pkg::ERR_INVALID, t0m, pm);
                        end else begin
                            s.btot  = info.count;
                            s.bleft = info.count;
                            do_run  = (info.count == 4'd0);
                        end
                    end else if (s.phase == PH_CMD) begin
                        if (s.bleft != 4'd0) begin
                            s = f_store(s, s.btot - s.bleft, i_item.data_in);
                            s.bleft = s.bleft - 1'b1;
                        end
                        do_run = (s.bleft == 4'd0);
                    end
                end
                // command execution, unit as set by the first parameter byte
                if (do_run) begin
                    code = s.cmd[4:0];
                    unit = s.cf[0][1:0];
                    if (fdc_pkg::f_is_rw(code)) begin
                        s.irq[unit] = s.irq[unit] & 8'h3C;
                        s.btot  = '0;
                        s.bleft = '0;
                        s.st1   = '0;
                        s.st2   = '0;
                        if (!s.dr[unit]) begin
                            s = f_begin(s, fdc_pkg::ERR_NOT_READY, t0m, pm);
                        end else if ((s.cmd & 8'h13) == 8'h01 && pm[unit]) begin
                            s = f_begin(s, fdc_pkg::ERR_PROTECT, t0m, pm);
                        end else begin
                            s.phase = PH_EXEC;
                            s.rd    = !s.cmd[0];
                            s.nrf   = 1'b1;
                            res.exec_start   = 1'b1;
                            res.exec_command = s.cmd;
                        end
                    end else if (code == fdc_pkg::CMD_SENSE_DRV ||
                                 code == fdc_pkg::CMD_SENSE_INT) begin
                        s = f_begin(s, fdc_pkg::ERR_NONE, t0m, pm);
                    end else if (code == fdc_pkg::CMD_RECAL) begin
                        s.irq[unit] = s.irq[unit] & 8'h3C;
                        s.pc[unit]  = '0;
                        s.tc[unit]  = '0;
                        if (!s.dr[unit]) begin
                            s = f_seek_done(s, unit, 1'b1, 1'b1, t0m[unit]);
                        end else if (t0m[unit]) begin
                            s = f_seek_done(s, unit, 1'b1, 1'b0, t0m[unit]);
                        end else begin
                            s.rl[unit]  = 7'(RECAL_MAX_STEPS);
                            s.tmr[unit] = s.sp;
                        end
                        s.phase = PH_IDLE;
                    end else if (code == fdc_pkg::CMD_SEEK) begin
                        s.irq[unit] = s.irq[unit] & 8'h3C;
                        s.rl[unit]  = '0;
                        if (!s.dr[unit]) begin
                            s = f_seek_done(s, unit, 1'b0, 1'b1, t0m[unit]);
                        end else if (s.tc[unit] == s.pc[unit]) begin
                            s = f_seek_done(s, unit, 1'b0, 1'b0, t0m[unit]);
                        end else begin
                            s.tmr[unit] = s.sp;
                        end
                        s.phase = PH_IDLE;
                    end else begin
                        s.phase = PH_IDLE;
                    end
                end
            end
            fdc_pkg::KIND_READ: begin
                if (s.rd && !s.nrf) begin
                    if (s.bleft != 4'd0) begin
                        idx = s.btot - s.bleft;
                        res.read_data = (idx < 4'd7) ? s.rb[idx[2:0]] : 8'h00;
                        if (s.phase == PH_EXEC) begin
                            s.nrf = 1'b1;
                            hold  = 1'b1;
                        end else begin
                            s.bleft = s.bleft - 1'b1;
                        end
                    end
                    if (!hold && s.bleft == 4'd0) begin
                        s.phase = PH_IDLE;
                        s.rd    = 1'b0;
                    end
                end
            end
            fdc_pkg::KIND_STATUS: begin
                res.read_data = {!s.nrf, s.rd, s.phase == PH_EXEC, s.phase != PH_IDLE, 4'd0};
                for (int i = 0; i < 4; i++) begin
                    if (s.tc[i] != s.pc[i] || s.rl[i] != 7'd0) res.read_data[i] = 1'b1;
                end
            end
            fdc_pkg::KIND_TICK: begin
                // per drive step engines
                for (int i = 0; i < 4; i++) begin
                    if (i < NUM_DRIVES) begin
                        if (s.rl[i] != 7'd0) begin
                            s.pc[i] = '0;
                            s.tc[i] = '0;
                            if (s.irq[i] >= 8'hC0) begin
                                s = f_seek_done(s, 2'(i), 1'b1, 1'b1, t0m[i]);
                            end else if (s.tmr[i] > 5'd1) begin
                                s.tmr[i] = s.tmr[i] - 1'b1;
                            end else begin
                                s.tmr[i] = s.sp;
                                res.step_out[i] = 1'b1;
                                s.rl[i] = s.rl[i] - 1'b1;
                                if (s.rl[i] == 7'd0 || t0m[i]) begin
                                    s = f_seek_done(s, 2'(i), 1'b1, 1'b0, t0m[i]);
                                end
                            end
                        end else if (s.tc[i] != s.pc[i]) begin
                            if (s.irq[i] >= 8'hC0) begin
                                s = f_seek_done(s, 2'(i), 1'b0, 1'b1, t0m[i]);
                            end else if (s.tmr[i] > 5'd1) begin
                                s.tmr[i] = s.tmr[i] - 1'b1;
                            end else begin
                                s.tmr[i] = s.sp;
                                if (s.tc[i] > s.pc[i]) begin
                                    res.step_in[i] = 1'b1;
                                    s.pc[i] = s.pc[i] + 1'b1;
                                end else begin
                                    res.step_out[i] = 1'b1;
                                    s.pc[i] = s.pc[i] - 1'b1;
                                end
                                if (s.pc[i] == s.tc[i]) begin
                                    s = f_seek_done(s, 2'(i), 1'b0, 1'b0, t0m[i]);
                                end
                            end
                        end
                    end
                end
            end
            fdc_pkg::KIND_FINISH: begin
                if (s.phase == PH_EXEC) begin
                    s.st1   = i_item.status1;
                    s.st2   = i_item.status2;
                    s.cf[2] = i_item.cylinder;
                    s.cf[3] = i_item.head;
                    s.cf[4] = i_item.sector;
                    s.cf[5] = i_item.size;
                    s = f_begin(s, i_item.error, t0m, pm);
                end
            end
            default: s = s;
        endcase
        n_st = s;
    end

    // controller state, result store kept across reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase  <= PH_IDLE;
            r_st.rd     <= 1'b0;
            r_st.nrf    <= 1'b0;
            r_st.cmd    <= '0;
            r_st.btot   <= '0;
            r_st.bleft  <= '0;
            r_st.cf     <= '0;
            r_st.st1    <= '0;
            r_st.st2    <= '0;
            r_st.sp     <= 5'd6;
            r_st.unload <= 8'd16;
            r_st.load   <= 8'd2;
            r_st.pc     <= '0;
            r_st.tc     <= '0;
            r_st.rl     <= '0;
            r_st.tmr    <= '0;
            r_st.irq    <= '0;
            r_st.dr     <= '0;
        end else if (o_take) begin
            r_st <= n_st;
        end
    end

    // result queue toward the host side
    fdc_fifo #(
        .WIDTH ($bits(fdc_pkg::t_result)),
        .DEPTH (2)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (o_take),
        .i_din   (res),
        .o_full  (out_full),
        .i_rd    (i_pop),
        .o_dout  (dout),
        .o_empty (o_empty)
    );

    assign out_res           = fdc_pkg::t_result'(dout);
    assign o_read_data       = out_res.read_data;
    assign o_step_out_pulses = out_res.step_out;
    assign o_step_in_pulses  = out_res.step_in;
    assign o_exec_start      = out_res.exec_start;
    assign o_exec_command    = out_res.exec_command;

    `FDC_ASSERT_IMPL(a_nrf_exec, r_st.nrf, r_st.phase == PH_EXEC)
    `FDC_ASSERT_IMPL(a_start_exec, o_take && res.exec_start, n_st.phase == PH_EXEC)
    `FDC_ASSERT_IMPL(a_left_total, 1'b1, r_st.bleft <= r_st.btot)
endmodule

// File: rtl/fdc_command_result_seek_engine_core.sv
// top level of the floppy controller front end with seek engines
// depends on fdc_pkg, fdc_front, fdc_back and fdc_fifo
//
// Bus accesses, 2 ms ticks and executor finish items enter through a push/full
// queue and each gives exactly one result item on the empty/pop side. While an
// item waits and the result queue is not full, one item is taken per clock
// cycle. Each item passes through the input queue, then the execution stage
// that updates all controller and per drive step state at once and writes the
// result queue. Each side has a two entry queue to absorb a short stall of the
// other; a full result queue stops taking, which in turn fills the input queue.
module fdc_command_result_seek_engine_core #(
    parameter int NUM_DRIVES      = 4,
    parameter int RECAL_MAX_STEPS = 77
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_data_in,
    input  logic [3:0] i_ready_lines,
    input  logic [3:0] i_track0_lines,
    input  logic [3:0] i_protect_lines,
    input  logic [7:0] i_finish_status1,
    input  logic [7:0] i_finish_status2,
    input  logic [2:0] i_finish_error,
    input  logic [7:0] i_finish_cylinder,
    input  logic [7:0] i_finish_head,
    input  logic [7:0] i_finish_sector,
    input  logic [7:0] i_finish_size,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_read_data,
    output logic [3:0] o_step_out_pulses,
    output logic [3:0] o_step_in_pulses,
    output logic       o_exec_start,
    output logic [7:0] o_exec_command
);
    logic           valid, take;
    fdc_pkg::t_item item;

    // accept and classify
    fdc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_kind            (i_kind),
        .i_data_in         (i_data_in),
        .i_ready_lines     (i_ready_lines),
        .i_track0_lines    (i_track0_lines),
        .i_protect_lines   (i_protect_lines),
        .i_finish_status1  (i_finish_status1),
        .i_finish_status2  (i_finish_status2),
        .i_finish_error    (i_finish_error),
        .i_finish_cylinder (i_finish_cylinder),
        .i_finish_head     (i_finish_head),
        .i_finish_sector   (i_finish_sector),
        .i_finish_size     (i_finish_size),
        .i_take            (take),
        .o_valid           (valid),
        .o_item            (item)
    );

    // execute and queue results
    fdc_back #(
        .NUM_DRIVES      (NUM_DRIVES),
        .RECAL_MAX_STEPS (RECAL_MAX_STEPS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (valid),
        .o_take            (take),
        .i_item            (item),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_read_data       (o_read_data),
        .o_step_out_pulses (o_step_out_pulses),
        .o_step_in_pulses  (o_step_in_pulses),
        .o_exec_start      (o_exec_start),
        .o_exec_command    (o_exec_command)
    );
endmodule
